// ===== rtl/core/setb_pkg.sv =====
// ----------------------------------------------------------------------------
// setb_pkg: shared definitions for the sparse entry tile binner
// Register indexes, result codes, defaults and controller/datapath structs.
// ----------------------------------------------------------------------------
package setb_pkg;

    // Width of every configuration register.
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_TILES   = 1024;
    localparam int DEF_COORD_WIDTH = 24;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam logic [CFG_W-1:0] MATRIX_ROWS_RESET = CFG_W'(1);
    localparam logic [CFG_W-1:0] MATRIX_COLS_RESET = CFG_W'(1);
    localparam logic [CFG_W-1:0] TILE_SIZE_RESET   = CFG_W'(1000000);

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MATRIX_COLS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE   = 2'd2;

    // Result status codes.
    localparam int STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_BINNED  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OUTSIDE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BEYOND  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READOUT = 2'd3;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic div_step;
        logic mul;
        logic idx;
        logic rd;
        logic fin;
        logic clr;
    } setb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic out_busy;
    } setb_stat_t;

endpackage

// ===== rtl/core/sparse_entry_tile_binner_top.sv =====
// ----------------------------------------------------------------------------
// sparse_entry_tile_binner_top: square tiling of sparse-matrix entries
// Bins 1-based coordinates into row-major tiles and keeps per-tile counts.
// ----------------------------------------------------------------------------
// Sequence: an entry request runs the bit-serial divider steps, then the multiply,
// index, read and count states (DIV_W = max(COORD_WIDTH, 24), 24 by default);
// a count readout runs only the read and count states. A finished result waits
// while the output register is full. One request is in work at a time.
// Reset: registers return to rows 1, cols 1, tile size 1000000, then a clearing
// pass zeroes the count memory while s_tready stays low.
module sparse_entry_tile_binner_top
    import setb_pkg::*;
#(
    parameter int MAX_TILES   = DEF_MAX_TILES,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    localparam int TILE_W     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1,
    localparam int DIV_W      = (COORD_WIDTH > CFG_W) ? COORD_WIDTH : CFG_W,
    localparam int S_FIELDS_W = 2 * COORD_WIDTH + TILE_W,
    localparam int S_DATA_W   = (S_FIELDS_W + 7) / 8 * 8,
    localparam int M_FIELDS_W = TILE_W + 2 * COORD_WIDTH + COUNT_WIDTH,
    localparam int M_DATA_W   = (M_FIELDS_W + 7) / 8 * 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,   // entry_row, entry_col, tile_select
    input  logic                 s_tuser,   // kind

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // tile_index, local_row, local_col, tile_count
    output logic [STATUS_W-1:0]  m_tuser    // status
);

    logic [COORD_WIDTH-1:0] entry_row;
    logic [COORD_WIDTH-1:0] entry_col;
    logic [TILE_W-1:0]      tile_select;
    logic [TILE_W-1:0]      tile_index;
    logic [COORD_WIDTH-1:0] local_row;
    logic [COORD_WIDTH-1:0] local_col;
    logic [COUNT_WIDTH-1:0] tile_count;
    setb_cmd_t              cmd;
    setb_stat_t             stat;

    assign entry_row   = s_tdata[COORD_WIDTH-1:0];
    assign entry_col   = s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
    assign tile_select = s_tdata[S_FIELDS_W-1:2*COORD_WIDTH];

    assign m_tdata = M_DATA_W'({tile_count, local_col, local_row, tile_index});

    setb_ctrl #(.DIV_W(DIV_W)) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    setb_datapath #(
        .MAX_TILES   (MAX_TILES),
        .COORD_WIDTH (COORD_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH),
        .TILE_W      (TILE_W),
        .DIV_W       (DIV_W)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .kind        (s_tuser),
        .entry_row   (entry_row),
        .entry_col   (entry_col),
        .tile_select (tile_select),
        .cmd         (cmd),
        .stat        (stat),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .status      (m_tuser),
        .tile_index  (tile_index),
        .local_row   (local_row),
        .local_col   (local_col),
        .tile_count  (tile_count)
    );

endmodule

// ===== rtl/core/setb_div.sv =====
// ----------------------------------------------------------------------------
// setb_div: bit-serial restoring divider lane
// Produces one quotient bit per step; the divisor is held by the caller.
// ----------------------------------------------------------------------------
module setb_div
    import setb_pkg::*;
#(
    parameter int DIV_W = DEF_COORD_WIDTH
)
(
    input  logic             clk,
    input  logic             load,
    input  logic             step,
    input  logic [DIV_W-1:0] dividend,
    input  logic [CFG_W-1:0] divisor,
    output logic [DIV_W-1:0] quotient,
    output logic [CFG_W-1:0] remainder
);

    logic [DIV_W-1:0] quot_reg;
    logic [DIV_W-1:0] quot_next;
    logic [CFG_W-1:0] rem_reg;
    logic [CFG_W-1:0] rem_next;
    logic [CFG_W:0]   shifted;

    always_comb
    begin
        shifted   = {rem_reg, quot_reg[DIV_W-1]};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        if (load)
        begin
            quot_next = dividend;
            rem_next  = '0;
        end
        else if (step)
        begin
            if (shifted >= {1'b0, divisor})
            begin
                rem_next  = CFG_W'(shifted - {1'b0, divisor});
                quot_next = {quot_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = shifted[CFG_W-1:0];
                quot_next = {quot_reg[DIV_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
    end

    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/setb_ctrl.sv =====
// ----------------------------------------------------------------------------
// setb_ctrl: sequencing state machine for the tile binner
// Runs the clearing pass, the division steps and the count update.
// ----------------------------------------------------------------------------
module setb_ctrl
    import setb_pkg::*;
#(
    parameter int DIV_W = DEF_COORD_WIDTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    input  logic       s_tuser,
    output logic       s_tready,
    input  setb_stat_t stat,
    output setb_cmd_t  cmd
);

    localparam int STEP_W = $clog2(DIV_W);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CLEAR = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_IDX   = 3'd4;
    localparam logic [2:0] ST_RD    = 3'd5;
    localparam logic [2:0] ST_CNT   = 3'd6;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    step_next  = '0;
                    state_next = s_tuser ? ST_RD : ST_DIV;
                end
            end
            ST_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_W - 1))
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_IDX;
            end
            ST_IDX:
            begin
                cmd.idx    = 1'b1;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = ST_CNT;
            end
            ST_CNT:
            begin
                // Hold the finished count until the output register is free.
                if (!stat.out_busy)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cmd))
        else $error("more than one datapath command at once");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while the previous one is in work");

    a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && !s_tuser) |=> (state_reg == ST_DIV && step_reg == '0))
        else $error("entry request did not start the division");

endmodule

// ===== rtl/core/setb_datapath.sv =====
// ----------------------------------------------------------------------------
// setb_datapath: configuration, dividers, index math and count store
// Holds the tile count memory and the registered result.
// ----------------------------------------------------------------------------
module setb_datapath
    import setb_pkg::*;
#(
    parameter int MAX_TILES   = DEF_MAX_TILES,
    parameter int COORD_WIDTH = DEF_COORD_WIDTH,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
    parameter int TILE_W      = $clog2(DEF_MAX_TILES),
    parameter int DIV_W       = DEF_COORD_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_W-1:0]       cfg_data,
    input  logic                   kind,
    input  logic [COORD_WIDTH-1:0] entry_row,
    input  logic [COORD_WIDTH-1:0] entry_col,
    input  logic [TILE_W-1:0]      tile_select,
    input  setb_cmd_t              cmd,
    output setb_stat_t             stat,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [STATUS_W-1:0]    status,
    output logic [TILE_W-1:0]      tile_index,
    output logic [COORD_WIDTH-1:0] local_row,
    output logic [COORD_WIDTH-1:0] local_col,
    output logic [COUNT_WIDTH-1:0] tile_count
);

    localparam int PW = DIV_W + CFG_W + 1;

    logic [CFG_W-1:0]       rows_reg;
    logic [CFG_W-1:0]       cols_reg;
    logic [CFG_W-1:0]       tsize_reg;
    logic [CFG_W-1:0]       ts_eff;

    logic                   kind_reg;
    logic [TILE_W-1:0]      sel_reg;
    logic                   sel_ok_reg;
    logic                   outside_reg;

    logic [DIV_W-1:0]       q_row;
    logic [DIV_W-1:0]       q_col;
    logic [DIV_W-1:0]       q_cols;
    logic [CFG_W-1:0]       r_row;
    logic [CFG_W-1:0]       r_col;
    logic [CFG_W:0]         per_row;

    logic [PW-1:0]          prod_reg;
    logic [PW-1:0]          idx_sum;
    logic [TILE_W-1:0]      idx_reg;
    logic                   beyond_reg;

    logic [COUNT_WIDTH-1:0] mem [MAX_TILES];
    logic [COUNT_WIDTH-1:0] rd_data_reg;
    logic [TILE_W-1:0]      rd_addr;
    logic [TILE_W-1:0]      clr_addr_reg;
    logic                   mem_we;
    logic [TILE_W-1:0]      mem_wa;
    logic [COUNT_WIDTH-1:0] mem_wd;

    logic                   binned;
    logic [COUNT_WIDTH-1:0] cnt_new;

    logic                   m_tvalid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [TILE_W-1:0]      tile_index_reg;
    logic [COORD_WIDTH-1:0] local_row_reg;
    logic [COORD_WIDTH-1:0] local_col_reg;
    logic [COUNT_WIDTH-1:0] tile_count_reg;

    // A tile size of zero behaves as a tile size of one.
    assign ts_eff = (tsize_reg == '0) ? CFG_W'(1) : tsize_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= MATRIX_ROWS_RESET;
            cols_reg  <= MATRIX_COLS_RESET;
            tsize_reg <= TILE_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MATRIX_ROWS: rows_reg  <= cfg_data;
                REG_MATRIX_COLS: cols_reg  <= cfg_data;
                REG_TILE_SIZE:   tsize_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg    <= kind;
            sel_reg     <= tile_select;
            sel_ok_reg  <= 32'(tile_select) < 32'(MAX_TILES);
            outside_reg <= (entry_row == '0) || (entry_col == '0)
                           || (DIV_W'(entry_row) > DIV_W'(rows_reg))
                           || (DIV_W'(entry_col) > DIV_W'(cols_reg));
        end
    end

    // Three lanes share one step: tile row, tile column and tiles per row.
    setb_div #(.DIV_W(DIV_W)) u_div_row (
        .clk       (clk),
        .load      (cmd.load),
        .step      (cmd.div_step),
        .dividend  (DIV_W'(entry_row - COORD_WIDTH'(1))),
        .divisor   (ts_eff),
        .quotient  (q_row),
        .remainder (r_row)
    );

    setb_div #(.DIV_W(DIV_W)) u_div_col (
        .clk       (clk),
        .load      (cmd.load),
        .step      (cmd.div_step),
        .dividend  (DIV_W'(entry_col - COORD_WIDTH'(1))),
        .divisor   (ts_eff),
        .quotient  (q_col),
        .remainder (r_col)
    );

    setb_div #(.DIV_W(DIV_W)) u_div_cols (
        .clk       (clk),
        .load      (cmd.load),
        .step      (cmd.div_step),
        .dividend  (DIV_W'(cols_reg - CFG_W'(1))),
        .divisor   (ts_eff),
        .quotient  (q_cols),
        .remainder ()
    );

    assign per_row = {1'b0, q_cols[CFG_W-1:0]} + (CFG_W + 1)'(1);
    assign idx_sum = prod_reg + PW'(q_col);

    always_ff @(posedge clk)
    begin
        if (cmd.mul)
        begin
            prod_reg <= PW'(q_row) * PW'(per_row);
        end
        if (cmd.idx)
        begin
            idx_reg    <= idx_sum[TILE_W-1:0];
            beyond_reg <= idx_sum >= PW'(MAX_TILES);
        end
    end

    // Count store: one write port shared by the clearing pass and updates.
    assign binned  = !kind_reg && !outside_reg && !beyond_reg;
    assign cnt_new = (&rd_data_reg) ? rd_data_reg : rd_data_reg + COUNT_WIDTH'(1);
    assign rd_addr = kind_reg ? sel_reg : idx_reg;
    assign mem_we  = cmd.clr || (cmd.fin && binned);
    assign mem_wa  = cmd.clr ? clr_addr_reg : idx_reg;
    assign mem_wd  = cmd.clr ? '0 : cnt_new;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clr)
        begin
            clr_addr_reg <= clr_addr_reg + TILE_W'(1);
        end
    end

    assign stat.clr_last = clr_addr_reg == TILE_W'(MAX_TILES - 1);
    assign stat.out_busy = m_tvalid_reg && !m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.fin)
        begin
            tile_index_reg <= '0;
            local_row_reg  <= '0;
            local_col_reg  <= '0;
            tile_count_reg <= '0;
            priority if (kind_reg)
            begin
                status_reg     <= ST_READOUT;
                tile_index_reg <= sel_reg;
                tile_count_reg <= sel_ok_reg ? rd_data_reg : '0;
            end
            else if (outside_reg)
            begin
                status_reg <= ST_OUTSIDE;
            end
            else if (beyond_reg)
            begin
                status_reg <= ST_BEYOND;
            end
            else
            begin
                status_reg     <= ST_BINNED;
                tile_index_reg <= idx_reg;
                local_row_reg  <= COORD_WIDTH'(r_row) + COORD_WIDTH'(1);
                local_col_reg  <= COORD_WIDTH'(r_col) + COORD_WIDTH'(1);
                tile_count_reg <= cnt_new;
            end
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign status     = status_reg;
    assign tile_index = tile_index_reg;
    assign local_row  = local_row_reg;
    assign local_col  = local_col_reg;
    assign tile_count = tile_count_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |-> !(m_tvalid_reg && !m_tready))
        else $error("result register overwritten before it was taken");

    a_valid_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(cmd.fin))
        else $error("result shown without a finished request");

    a_binned_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.fin && binned) |=> (tile_count_reg != '0))
        else $error("binned entry reported a zero count");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for sparse_entry_tile_binner_top
// Drives entry and count-readout requests over the input stream, keeps its own
// tile-count model and compares every result field by field, under several
// idle and backpressure patterns and several matrix geometries.
// ----------------------------------------------------------------------------
module tb_top;
    import setb_pkg::*;

    localparam int TILE_W     = 10;
    localparam int COORD_W    = 24;
    localparam int COUNT_W    = 32;
    localparam int NUM_TILES  = 1024;
    localparam int S_DATA_W   = 64;
    localparam int M_DATA_W   = 96;
    localparam int DRAIN_WAIT = 40;
    localparam int STALL_LIMIT = 5000;
    localparam int ITEMS_PER_PHASE = 135;

    localparam longint unsigned MAX_COORD = 64'hFF_FFFF;
    localparam logic [COUNT_W-1:0] COUNT_TOP = '1;

    // Index 3 is not a register; writes to it must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

    localparam logic KIND_ENTRY   = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [TILE_W-1:0]   tile_index;
        logic [COORD_W-1:0]  local_row;
        logic [COORD_W-1:0]  local_col;
        logic [COUNT_W-1:0]  tile_count;
    } bin_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 s_tuser = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    // Model state: geometry registers and per-tile nonzero counts.
    logic [CFG_W-1:0]   geo_rows;
    logic [CFG_W-1:0]   geo_cols;
    logic [CFG_W-1:0]   geo_tile_size;
    logic [COUNT_W-1:0] tile_hits [NUM_TILES];
    logic [TILE_W-1:0]  last_binned_tile = '0;

    bin_result_t pending_bins [$];
    bin_result_t seen_bin;
    bin_result_t want_bin;

    int errors = 0;
    int idle_cycles = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;

    sparse_entry_tile_binner_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #5 clk = ~clk;

    initial
    begin
        geo_rows      = MATRIX_ROWS_RESET;
        geo_cols      = MATRIX_COLS_RESET;
        geo_tile_size = TILE_SIZE_RESET;
        for (int i = 0; i < NUM_TILES; i++)
        begin
            tile_hits[i] = '0;
        end
    end

    // Works out the result of one request and updates the tile counts.
    function automatic bin_result_t bin_entry(input logic kind, input logic [COORD_W-1:0] row,
                                              input logic [COORD_W-1:0] col,
                                              input logic [TILE_W-1:0] sel);
        bin_result_t res;
        longint unsigned edge_len;
        longint unsigned tiles_across;
        longint unsigned tile_num;

        res = '0;
        if (kind == KIND_READOUT)
        begin
            res.status     = ST_READOUT;
            res.tile_index = sel;
            res.tile_count = tile_hits[sel];
            return res;
        end
        if (row == 0 || col == 0 || row > geo_rows || col > geo_cols)
        begin
            res.status = ST_OUTSIDE;
            return res;
        end
        edge_len     = (geo_tile_size == 0) ? 1 : longint'(geo_tile_size);
        tiles_across = (longint'(geo_cols) - 1) / edge_len + 1;
        tile_num     = ((longint'(row) - 1) / edge_len) * tiles_across
                       + (longint'(col) - 1) / edge_len;
        if (tile_num >= NUM_TILES)
        begin
            res.status = ST_BEYOND;
            return res;
        end
        if (tile_hits[tile_num] != COUNT_TOP)
        begin
            tile_hits[tile_num] = tile_hits[tile_num] + 1;
        end
        last_binned_tile = TILE_W'(tile_num);
        res.status     = ST_BINNED;
        res.tile_index = TILE_W'(tile_num);
        res.local_row  = COORD_W'((longint'(row) - 1) % edge_len + 1);
        res.local_col  = COORD_W'((longint'(col) - 1) % edge_len + 1);
        res.tile_count = tile_hits[tile_num];
        return res;
    endfunction

    task automatic send_request(input logic kind, input logic [COORD_W-1:0] row,
                                input logic [COORD_W-1:0] col, input logic [TILE_W-1:0] sel);
        @(negedge clk);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {6'b0, sel, col, row};
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        pending_bins.push_back(bin_entry(kind, row, col, sel));
    endtask

    // Stops sending and waits until every expected result has come back.
    task automatic drain_requests();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_bins.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (index)
            REG_MATRIX_ROWS: geo_rows = value;
            REG_MATRIX_COLS: geo_cols = value;
            REG_TILE_SIZE:   geo_tile_size = value;
            default: ;
        endcase
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                                input logic [CFG_W-1:0] tile_len);
        write_register(REG_MATRIX_ROWS, rows);
        write_register(REG_MATRIX_COLS, cols);
        write_register(REG_TILE_SIZE, tile_len);
    endtask

    // Runs right after reset, so the first request also waits out the clearing pass.
    task automatic test_reset_defaults();
        send_request(KIND_ENTRY, 24'd1, 24'd1, 10'd0);
        send_request(KIND_ENTRY, 24'd2, 24'd1, 10'd0);
        send_request(KIND_ENTRY, 24'd1, 24'd0, 10'd0);
        send_request(KIND_ENTRY, 24'd0, 24'd1, 10'd0);
        send_request(KIND_READOUT, 24'd0, 24'd0, 10'd0);
        send_request(KIND_READOUT, 24'hFF_FFFF, 24'hFF_FFFF, 10'd1023);
        drain_requests();
    endtask

    task automatic test_tile_geometry();
        set_geometry(24'd100, 24'd70, 24'd30);
        send_request(KIND_ENTRY, 24'd1, 24'd1, 10'd0);
        send_request(KIND_ENTRY, 24'd100, 24'd70, 10'd0);
        send_request(KIND_ENTRY, 24'd31, 24'd61, 10'd0);
        send_request(KIND_ENTRY, 24'd30, 24'd30, 10'd0);
        send_request(KIND_ENTRY, 24'd101, 24'd5, 10'd0);
        send_request(KIND_ENTRY, 24'd5, 24'd71, 10'd0);
        send_request(KIND_READOUT, 24'd0, 24'd0, 10'd11);
        drain_requests();
        // A zero row count puts every entry outside the matrix.
        write_register(REG_MATRIX_ROWS, 24'd0);
        send_request(KIND_ENTRY, 24'd1, 24'd1, 10'd0);
        drain_requests();
    endtask

    task automatic test_tile_size_extremes();
        // Largest tile: the whole matrix is one tile and local coordinates reach the top.
        set_geometry(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
        send_request(KIND_ENTRY, 24'hFF_FFFF, 24'hFF_FFFF, 10'd0);
        drain_requests();
        // Zero tile size acts as one, so 256 tiles across and row 4 ends at tile 1023.
        set_geometry(24'd5, 24'd256, 24'd0);
        send_request(KIND_ENTRY, 24'd4, 24'd256, 10'd0);
        send_request(KIND_ENTRY, 24'd5, 24'd1, 10'd0);
        send_request(KIND_READOUT, 24'd0, 24'd0, 10'd1023);
        drain_requests();
        // Unit tiles on a huge matrix land far beyond the tile store.
        set_geometry(24'hFF_FFFF, 24'hFF_FFFF, 24'd1);
        send_request(KIND_ENTRY, 24'hFF_FFFF, 24'hFF_FFFF, 10'd0);
        drain_requests();
    endtask

    task automatic test_unmapped_register();
        set_geometry(24'd8, 24'd8, 24'd4);
        write_register(REG_UNMAPPED, 24'hFF_FFFF);
        send_request(KIND_ENTRY, 24'd8, 24'd8, 10'd0);
        send_request(KIND_ENTRY, 24'd9, 24'd1, 10'd0);
        drain_requests();
    endtask

    // Tile size of random magnitude with a grid of up to 36 x 36 tiles, so a
    // few geometries overflow the tile store.
    task automatic pick_random_geometry();
        longint unsigned tile_len;
        longint unsigned rows;
        longint unsigned cols;

        tile_len = $urandom_range(1, 1 << $urandom_range(0, 23));
        rows = tile_len * $urandom_range(1, 36) - $urandom_range(0, tile_len - 1);
        cols = tile_len * $urandom_range(1, 36) - $urandom_range(0, tile_len - 1);
        if (rows > MAX_COORD)
        begin
            rows = MAX_COORD;
        end
        if (cols > MAX_COORD)
        begin
            cols = MAX_COORD;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            tile_len = 0;
            rows = $urandom_range(1, 36);
            cols = $urandom_range(1, 28);
        end
        set_geometry(CFG_W'(rows), CFG_W'(cols), CFG_W'(tile_len));
        write_register(REG_UNMAPPED, CFG_W'($urandom));
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int pick;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [TILE_W-1:0]  sel;

        pick_random_geometry();
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
        begin
            pick = $urandom_range(0, 99);
            row  = COORD_W'($urandom);
            col  = COORD_W'($urandom);
            sel  = TILE_W'($urandom);
            if (pick < 12)
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    sel = last_binned_tile;
                end
                send_request(KIND_READOUT, row, col, sel);
            end
            else if (pick < 85)
            begin
                row = COORD_W'($urandom_range(1, geo_rows));
                col = COORD_W'($urandom_range(1, geo_cols));
                send_request(KIND_ENTRY, row, col, sel);
            end
            else
            begin
                // Malformed coordinates: zero, just past the edge, or anything.
                if (pick < 90)
                begin
                    row = '0;
                end
                else if (pick < 95 && geo_cols != MAX_COORD)
                begin
                    row = COORD_W'($urandom_range(1, geo_rows));
                    col = COORD_W'(geo_cols + 1);
                end
                send_request(KIND_ENTRY, row, col, sel);
            end
        end
        drain_requests();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_tile_geometry();
        test_tile_size_extremes();
        test_unmapped_register();
        test_random_traffic(0, 0);
        test_random_traffic(85, 0);
        test_random_traffic(0, 85);
        test_random_traffic(16, 16);
        if (errors == 0 && pending_bins.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    task automatic compare_field(input string field, input longint unsigned want,
                                 input longint unsigned got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            // The bus carries tile_index in the lowest bits; the struct keeps it high.
            seen_bin = {m_tuser, m_tdata[9:0], m_tdata[33:10], m_tdata[57:34],
                        m_tdata[89:58]};
            if (pending_bins.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d tile %0d",
                         $time, seen_bin.status, seen_bin.tile_index);
                errors++;
            end
            else
            begin
                want_bin = pending_bins.pop_front();
                compare_field("status", want_bin.status, seen_bin.status);
                compare_field("tile_index", want_bin.tile_index, seen_bin.tile_index);
                compare_field("local_row", want_bin.local_row, seen_bin.local_row);
                compare_field("local_col", want_bin.local_col, seen_bin.local_col);
                compare_field("tile_count", want_bin.tile_count, seen_bin.tile_count);
            end
        end
    end

    // Ends the run when neither side has moved a request for too long.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no request moved for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule
